// ===== design/sgcb_pkg.sv =====
`default_nettype none

package sgcb_pkg;

  localparam int CW     = 4;   // row / column number
  localparam int NW     = 5;   // grid size register
  localparam int IDXW   = 8;
  localparam int TAGW   = 16;
  localparam int CRDW   = 16;
  localparam int PW     = 40;  // product, quotient and crossing value
  localparam int DVW    = 17;  // endpoint difference
  localparam int MAXRES = 64;
  localparam int RESW   = 7;
  localparam int KW     = 6;
  localparam int NCAND  = 3;
  localparam logic [TAGW-1:0] NO_SEGMENT = 16'hFFFF;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_COLUMNS  = 2'd2;
  localparam logic [1:0] REG_ROWS     = 2'd3;

  typedef struct packed {
    logic signed [CRDW-1:0] start_x;
    logic signed [CRDW-1:0] start_y;
    logic signed [CRDW-1:0] end_x;
    logic signed [CRDW-1:0] end_y;
    logic [TAGW-1:0]        segment_id;
  } in_t;

  typedef struct packed {
    logic [IDXW-1:0] cell_index;
    logic [TAGW-1:0] segment_tag;
    logic            endpoint_outside;
    logic            last_cell;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_FLAG, ST_ADD_RD, ST_ADD_CMP, ST_LOOP,
    ST_MUL, ST_DIV, ST_CROSS, ST_OUT_RD, ST_OUT_LOAD
  } state_e;

  typedef enum logic {PH_COLS, PH_ROWS} phase_e;

  function automatic logic [IDXW-1:0] cell_idx(logic [CW-1:0] col, logic [CW-1:0] row,
                                                logic [NW-1:0] n);
    logic [8:0] t;
    t = 9'(row) * 9'(n) + 9'(col);
    return t[IDXW-1:0];
  endfunction

  function automatic logic outside(logic signed [DVW-1:0] b, logic [NW-1:0] n);
    return b[DVW-1] || (b >= $signed({12'd0, n}));
  endfunction

  function automatic logic [NW-1:0] clamp_size(logic [NW-1:0] v, logic [NW-1:0] hi);
    logic [NW-1:0] s;
    s = (v == '0) ? NW'(1) : v;
    return (s > hi) ? hi : s;
  endfunction

endpackage

`default_nettype wire

// ===== design/sgcb_div.sv =====
`default_nettype none

module sgcb_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic signed [sgcb_pkg::PW-1:0]   dividend_i,
  input  wire logic signed [sgcb_pkg::DVW-1:0]  divisor_i,
  output logic                                  done_o,
  output logic signed [sgcb_pkg::PW-1:0]        quotient_o
);
  import sgcb_pkg::*;

  logic          busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [DVW:0]  rem_q, rem_d, rem_sh;
  logic [DVW-1:0] dvs_q, dvs_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    rem_sh = {rem_q[DVW-1:0], quo_q[PW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'(PW);
      quo_d  = dividend_i[PW-1] ? PW'(-dividend_i) : PW'(dividend_i);
      dvs_d  = divisor_i[DVW-1] ? DVW'(-divisor_i) : DVW'(divisor_i);
      neg_d  = dividend_i[PW-1] ^ divisor_i[DVW-1];
      rem_d  = '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        quo_d = {quo_q[PW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[PW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? $signed(-quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

// ===== design/segment_grid_cell_binner_top.sv =====
// channel | signals                           | word
// in      | in_valid_i, in_stall_o, in_word_i  | one segment (sgcb_pkg::in_t)
// out     | out_valid_o, out_stall_i, out_word_o | one cell (sgcb_pkg::out_t)
// cfg     | cfg_we_i, cfg_index_i, cfg_data_i  | register write, no wait
// One segment at a time. Endpoints are entered first, then each grid edge crossed waits
// on the 1-bit-per-cycle divider before its candidate cells are entered; an edge
// beyond the segment is skipped. Results leave one by one from the buffer.
// Tag memory valid bits are cleared by reset at once, no clearing pass.
// in_stall_o is high while a segment is in work; out_stall_i holds the output word.
`default_nettype none

module segment_grid_cell_binner_top #(
  parameter int CELL_SHIFT  = 7,
  parameter int MAX_COLUMNS = 16,
  parameter int MAX_ROWS    = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire sgcb_pkg::in_t  in_word_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output sgcb_pkg::out_t      out_word_o,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [15:0]    cfg_data_i
);
  import sgcb_pkg::*;

  localparam logic [NW-1:0] MAXC = NW'(MAX_COLUMNS);
  localparam logic [NW-1:0] MAXR = NW'(MAX_ROWS);

  logic signed [CRDW-1:0] org_x_q, org_y_q;
  logic [NW-1:0]          cols_q, rows_q, ncols, nrows;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic signed [CRDW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [TAGW-1:0]        id_q;
  logic [NW-1:0]          j_q, j_d;
  logic [RESW-1:0]        cnt_q, cnt_d;
  logic [KW-1:0]          k_q, k_d;
  logic [1:0]             slot_q, slot_d;
  logic [NCAND-1:0]       cv_q, cv_d;
  logic [CW-1:0]          ccol_q [NCAND];
  logic [CW-1:0]          ccol_d [NCAND];
  logic [CW-1:0]          crow_q [NCAND];
  logic [CW-1:0]          crow_d [NCAND];
  logic [IDXW-1:0]        addr_q, addr_d;
  logic signed [17:0]     crd_q, crd_d;
  logic signed [18:0]     diff_q, diff_d;
  out_t                   out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  logic [TAGW-1:0] tag_mem [256];
  logic [255:0]    tag_vld_q;
  logic [TAGW-1:0] tag_rd_q;
  logic            vld_rd_q, tag_re, tag_we;
  logic [IDXW-1:0] emit_mem [MAXRES];
  logic [IDXW-1:0] emit_rd_q;
  logic            emit_re, emit_we;

  logic signed [DVW-1:0] dx, dy, ox1, oy1, ox2, oy2, bx1, by1, bx2, by2;
  logic signed [CRDW-1:0] minx, maxx, miny, maxy;
  logic sneg, spos, vert, horiz, out_free;

  logic signed [CRDW-1:0] org_a, org_b, base_a, base_b, lo_a, hi_a, lo_b;
  logic signed [DVW-1:0]  dnum, dden;
  logic [NW-1:0]          lim_a, lim_b;
  logic signed [17:0]     crd;
  logic signed [18:0]     diff;
  logic signed [35:0]     prod;
  logic                   div_start, div_done;
  logic signed [PW-1:0]   quot, v, off, b, lim_s;
  logic [CELL_SHIFT-1:0]  p;
  logic [CW-1:0]          b4, j4;
  logic                   lt_a, lt_b, b_out;

  assign ncols = clamp_size(cols_q, MAXC);
  assign nrows = clamp_size(rows_q, MAXR);

  assign dx   = DVW'(x2_q) - DVW'(x1_q);
  assign dy   = DVW'(y2_q) - DVW'(y1_q);
  assign minx = (x1_q < x2_q) ? x1_q : x2_q;
  assign maxx = (x1_q < x2_q) ? x2_q : x1_q;
  assign miny = (y1_q < y2_q) ? y1_q : y2_q;
  assign maxy = (y1_q < y2_q) ? y2_q : y1_q;
  assign sneg  = dx[DVW-1] ^ dy[DVW-1];
  assign spos  = !sneg && (dx != dy);
  assign vert  = (dx == '0);
  assign horiz = (dy == '0);
  assign ox1 = DVW'(x1_q) - DVW'(org_x_q);
  assign oy1 = DVW'(y1_q) - DVW'(org_y_q);
  assign ox2 = DVW'(x2_q) - DVW'(org_x_q);
  assign oy2 = DVW'(y2_q) - DVW'(org_y_q);
  assign bx1 = ox1 >>> CELL_SHIFT;
  assign by1 = oy1 >>> CELL_SHIFT;
  assign bx2 = ox2 >>> CELL_SHIFT;
  assign by2 = oy2 >>> CELL_SHIFT;

  assign out_free = !out_valid_q || !out_stall_i;

  // axis a is the one walked by j, axis b the computed crossing
  always_comb begin
    if (phase_q == PH_COLS) begin
      org_a = org_x_q; org_b = org_y_q; base_a = x1_q; base_b = y1_q;
      lo_a = minx; hi_a = maxx; lo_b = miny; dnum = dy; dden = dx;
      lim_a = ncols; lim_b = nrows;
    end else begin
      org_a = org_y_q; org_b = org_x_q; base_a = y1_q; base_b = x1_q;
      lo_a = miny; hi_a = maxy; lo_b = minx; dnum = dx; dden = dy;
      lim_a = nrows; lim_b = ncols;
    end
  end

  assign crd   = 18'(org_a) + $signed(18'({13'd0, j_q}) << CELL_SHIFT);
  assign diff  = 19'(crd) - 19'(base_a);
  assign prod  = dnum * diff_q;
  assign v     = quot + PW'(base_b);
  assign off   = v - PW'(org_b);
  assign b     = off >>> CELL_SHIFT;
  assign p     = off[CELL_SHIFT-1:0];
  assign lim_s = PW'({1'b0, lim_b});
  assign b_out = b[PW-1] || (b >= lim_s);
  assign b4    = b[CW-1:0];
  assign j4    = j_q[CW-1:0];
  assign lt_a  = 18'(lo_a) < crd_q;
  assign lt_b  = PW'(lo_b) < v;

  sgcb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (PW'(prod)),
    .divisor_i  (dden),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    j_d         = j_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    slot_d      = slot_q;
    cv_d        = cv_q;
    ccol_d      = ccol_q;
    crow_d      = crow_q;
    addr_d      = addr_q;
    crd_d       = crd_q;
    diff_d      = diff_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    tag_re      = 1'b0;
    tag_we      = 1'b0;
    emit_re     = 1'b0;
    emit_we     = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        cnt_d = '0;
        if (outside(bx1, ncols) || outside(by1, nrows) ||
            outside(bx2, ncols) || outside(by2, nrows)) begin
          state_d = ST_FLAG;
        end else begin
          ccol_d[0] = bx1[CW-1:0]; crow_d[0] = by1[CW-1:0];
          ccol_d[1] = bx2[CW-1:0]; crow_d[1] = by2[CW-1:0];
          cv_d      = 3'b011;
          slot_d    = '0;
          phase_d   = PH_COLS;
          j_d       = '0;
          state_d   = ST_ADD_RD;
        end
      end
      ST_FLAG: begin
        if (out_free) begin
          out_d       = '{cell_index: '0, segment_tag: id_q, endpoint_outside: 1'b1,
                          last_cell: 1'b1};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_ADD_RD: begin
        if (slot_q == 2'd3) begin
          state_d = ST_LOOP;
        end else if (!cv_q[slot_q]) begin
          slot_d = slot_q + 2'd1;
        end else begin
          addr_d  = cell_idx(ccol_q[slot_q], crow_q[slot_q], ncols);
          tag_re  = 1'b1;
          state_d = ST_ADD_CMP;
        end
      end
      ST_ADD_CMP: begin
        if (((vld_rd_q ? tag_rd_q : NO_SEGMENT) != id_q) && (cnt_q < RESW'(MAXRES))) begin
          tag_we  = 1'b1;
          emit_we = 1'b1;
          cnt_d   = cnt_q + RESW'(1);
        end
        slot_d  = slot_q + 2'd1;
        state_d = ST_ADD_RD;
      end
      ST_LOOP: begin
        if (phase_q == PH_COLS && (vert || j_q == lim_a)) begin
          phase_d = PH_ROWS;
          j_d     = '0;
        end else if (phase_q == PH_ROWS && (horiz || j_q == lim_a)) begin
          k_d     = '0;
          state_d = (cnt_q == '0) ? ST_IDLE : ST_OUT_RD;
        end else if (crd < 18'(lo_a) || crd > 18'(hi_a)) begin
          j_d = j_q + NW'(1);
        end else begin
          crd_d   = crd;
          diff_d  = diff;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_CROSS;
      end
      ST_CROSS: begin
        cv_d   = '0;
        slot_d = '0;
        j_d    = j_q + NW'(1);
        if (!b_out) begin
          cv_d[0] = 1'b1;
          if (phase_q == PH_COLS) begin
            ccol_d = '{j4, j4, j4 - 4'd1};
            crow_d = '{b4, b4 - 4'd1, b4};
            if (p == '0) begin
              if (sneg) begin
                cv_d[1] = (b4 != '0) && lt_b;
                cv_d[2] = (j4 != '0) && lt_a;
              end else if (spos) begin
                ccol_d[1] = j4 - 4'd1;
                cv_d[1]   = (b4 != '0) && (j4 != '0) && lt_a;
              end else if (horiz) begin
                cv_d[2] = (j4 != '0) && lt_a;
              end
            end else begin
              cv_d[2] = (j4 != '0) && lt_a;
            end
          end else begin
            ccol_d = '{b4, b4, b4 - 4'd1};
            crow_d = '{j4, j4 - 4'd1, j4};
            if (p == '0) begin
              if (sneg) begin
                cv_d[1] = (j4 != '0) && lt_a;
                cv_d[2] = (b4 != '0) && lt_b;
              end else if (vert) begin
                cv_d[1] = (j4 != '0) && lt_a;
              end else if (spos) begin
                ccol_d[1] = b4 - 4'd1;
                cv_d[1]   = (b4 != '0) && (j4 != '0) && lt_a;
              end
            end else begin
              cv_d[1] = (j4 != '0) && lt_a;
            end
          end
        end
        state_d = ST_ADD_RD;
      end
      ST_OUT_RD: begin
        emit_re = 1'b1;
        state_d = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        if (out_free) begin
          out_d       = '{cell_index: emit_rd_q, segment_tag: id_q, endpoint_outside: 1'b0,
                          last_cell: (RESW'(k_q) == cnt_q - RESW'(1))};
          out_valid_d = 1'b1;
          k_d         = k_q + KW'(1);
          state_d     = (RESW'(k_q) == cnt_q - RESW'(1)) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_COLS;
      out_valid_q <= 1'b0;
      tag_vld_q   <= '0;
      org_x_q     <= '0;
      org_y_q     <= '0;
      cols_q      <= NW'(16);
      rows_q      <= NW'(16);
      j_q         <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      slot_q      <= '0;
      cv_q        <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      slot_q      <= slot_d;
      cv_q        <= cv_d;
      if (tag_we) tag_vld_q[addr_q] <= 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_ORIGIN_X: org_x_q <= cfg_data_i;
          REG_ORIGIN_Y: org_y_q <= cfg_data_i;
          REG_COLUMNS:  cols_q  <= cfg_data_i[NW-1:0];
          REG_ROWS:     rows_q  <= cfg_data_i[NW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      x1_q <= in_word_i.start_x;
      y1_q <= in_word_i.start_y;
      x2_q <= in_word_i.end_x;
      y2_q <= in_word_i.end_y;
      id_q <= in_word_i.segment_id;
    end
    ccol_q <= ccol_d;
    crow_q <= crow_d;
    addr_q <= addr_d;
    crd_q  <= crd_d;
    diff_q <= diff_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[addr_q] <= id_q;
    if (tag_re) begin
      tag_rd_q <= tag_mem[addr_d];
      vld_rd_q <= tag_vld_q[addr_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_we) emit_mem[cnt_q[KW-1:0]] <= addr_q;
    if (emit_re) emit_rd_q <= emit_mem[k_q];
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ===== dv/segment_grid_cell_binner_top_tb.sv =====
`timescale 1ns / 1ps

module segment_grid_cell_binner_top_tb;
  import sgcb_pkg::*;

  localparam int SHIFT = 7;
  localparam int LIMIT = 10000000;

  class cell_scoreboard;
    longint org_x, org_y;
    int cols_reg, rows_reg;
    logic [15:0] tags [256];
    out_t cells_due[$];
    logic [7:0] found[$];
    logic [15:0] cur_id;
    int errors;

    function void reset_state();
      org_x = 0; org_y = 0; cols_reg = 16; rows_reg = 16;
      foreach (tags[i]) tags[i] = NO_SEGMENT;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] d);
      case (idx)
        REG_ORIGIN_X: org_x = longint'($signed(d));
        REG_ORIGIN_Y: org_y = longint'($signed(d));
        REG_COLUMNS:  cols_reg = int'(d[4:0]);
        REG_ROWS:     rows_reg = int'(d[4:0]);
        default: ;
      endcase
    endfunction

    function longint cell_of(longint v);
      return v >>> SHIFT;
    endfunction

    function void add(longint c, longint r, longint n);
      logic [7:0] idx;
      idx = 8'(r * n + c);
      if (tags[idx] == cur_id) return;
      if (found.size() >= MAXRES) return;
      tags[idx] = cur_id;
      found = {found, idx};
    endfunction

    function void note_segment(in_t w);
      longint x1, y1, x2, y2, nc, nr, dx, dy, mnx, mxx, mny, mxy, bx1, by1, bx2, by2;
      longint x, y, b, p, j;
      logic [63:0] sx;
      bit sneg, spos, vert, horiz;
      out_t o;
      x1 = longint'(w.start_x); y1 = longint'(w.start_y);
      x2 = longint'(w.end_x); y2 = longint'(w.end_y);
      nc = longint'(cols_reg < 1 ? 1 : (cols_reg > 16 ? 16 : cols_reg));
      nr = longint'(rows_reg < 1 ? 1 : (rows_reg > 16 ? 16 : rows_reg));
      dx = x2 - x1; dy = y2 - y1;
      mnx = x1 < x2 ? x1 : x2; mxx = x1 < x2 ? x2 : x1;
      mny = y1 < y2 ? y1 : y2; mxy = y1 < y2 ? y2 : y1;
      sx = dx ^ dy; sneg = sx[63]; spos = !sneg && sx != 0;
      vert = dx == 0; horiz = dy == 0;
      bx1 = cell_of(x1 - org_x); by1 = cell_of(y1 - org_y);
      bx2 = cell_of(x2 - org_x); by2 = cell_of(y2 - org_y);
      cur_id = w.segment_id;
      found.delete();
      if (bx1 < 0 || bx1 >= nc || by1 < 0 || by1 >= nr ||
          bx2 < 0 || bx2 >= nc || by2 < 0 || by2 >= nr) begin
        o = '{cell_index: 8'd0, segment_tag: cur_id, endpoint_outside: 1'b1, last_cell: 1'b1};
        cells_due = {cells_due, o};
        return;
      end
      add(bx1, by1, nc);
      add(bx2, by2, nc);
      if (!vert) begin
        for (j = 0; j < nc; j++) begin
          x = org_x + (j << SHIFT);
          y = (dy * (x - x1)) / dx + y1;
          b = cell_of(y - org_y); p = (y - org_y) & ((1 << SHIFT) - 1);
          if (b < 0 || b > nr - 1) continue;
          if (x < mnx || x > mxx) continue;
          add(j, b, nc);
          if (p == 0) begin
            if (sneg) begin
              if (b > 0 && mny < y) add(j, b - 1, nc);
              if (j > 0 && mnx < x) add(j - 1, b, nc);
            end else if (spos) begin
              if (b > 0 && j > 0 && mnx < x) add(j - 1, b - 1, nc);
            end else if (horiz) begin
              if (j > 0 && mnx < x) add(j - 1, b, nc);
            end
          end else if (j > 0 && mnx < x) add(j - 1, b, nc);
        end
      end
      if (!horiz) begin
        for (j = 0; j < nr; j++) begin
          y = org_y + (j << SHIFT);
          x = (dx * (y - y1)) / dy + x1;
          b = cell_of(x - org_x); p = (x - org_x) & ((1 << SHIFT) - 1);
          if (b < 0 || b > nc - 1) continue;
          if (y < mny || y > mxy) continue;
          add(b, j, nc);
          if (p == 0) begin
            if (sneg) begin
              if (j > 0 && mny < y) add(b, j - 1, nc);
              if (b > 0 && mnx < x) add(b - 1, j, nc);
            end else if (vert) begin
              if (j > 0 && mny < y) add(b, j - 1, nc);
            end else if (spos) begin
              if (b > 0 && j > 0 && mny < y) add(b - 1, j - 1, nc);
            end
          end else if (j > 0 && mny < y) add(b, j - 1, nc);
        end
      end
      foreach (found[k]) begin
        o = '{cell_index: found[k], segment_tag: cur_id, endpoint_outside: 1'b0,
              last_cell: (k == found.size() - 1)};
        cells_due = {cells_due, o};
      end
    endfunction

    function void check_cell(out_t got);
      out_t e;
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected cell word %p", $time, got);
        errors++;
        return;
      end
      e = cells_due.pop_front();
      if (got.cell_index !== e.cell_index) begin
        $display("%0t: cell_index exp %0d got %0d", $time, e.cell_index, got.cell_index);
        errors++;
      end
      if (got.segment_tag !== e.segment_tag) begin
        $display("%0t: segment_tag exp %0d got %0d", $time, e.segment_tag, got.segment_tag);
        errors++;
      end
      if (got.endpoint_outside !== e.endpoint_outside) begin
        $display("%0t: endpoint_outside exp %0b got %0b", $time, e.endpoint_outside,
                 got.endpoint_outside);
        errors++;
      end
      if (got.last_cell !== e.last_cell) begin
        $display("%0t: last_cell exp %0b got %0b", $time, e.last_cell, got.last_cell);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic in_valid_i = 1'b0, in_stall_o;
  in_t in_word_i = '0;
  logic out_valid_o, out_stall_i = 1'b0;
  out_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = REG_ORIGIN_X;
  logic [15:0] cfg_data_i = '0;

  cell_scoreboard sb;
  int cycles = 0;
  bit hold_off = 1'b0;
  logic [15:0] next_id = 16'd0;

  segment_grid_cell_binner_top dut (.*);

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_cell(out_word_o);

  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_off = 1'b0;
      end else begin
        n = $urandom_range(0, 7);
        out_stall_i <= (n < 3) ? 1'b1 : 1'b0;
        if (n == 7) begin
          repeat ($urandom_range(10, 60)) @(posedge clk_i);
        end
      end
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [15:0] d);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= d;
    @(posedge clk_i);
    sb.write_reg(idx, d);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_segment(in_t w, bit keep);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_segment(w);
    if (!keep) in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.cells_due.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
  endtask

  function automatic logic [15:0] coord_near(longint org, int n);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'(org + $urandom_range(0, n * 128 - 1) - ($urandom_range(0, 15) == 0 ? 8 : 0));
  endfunction

  function automatic logic [15:0] snap(logic [15:0] v);
    return ($urandom_range(0, 2) == 0) ? {v[15:7], 7'd0} : v;
  endfunction

  function automatic in_t rand_segment();
    in_t w;
    int nc, nr;
    nc = sb.cols_reg < 1 ? 1 : (sb.cols_reg > 16 ? 16 : sb.cols_reg);
    nr = sb.rows_reg < 1 ? 1 : (sb.rows_reg > 16 ? 16 : sb.rows_reg);
    w.start_x = snap(coord_near(sb.org_x, nc));
    w.start_y = snap(coord_near(sb.org_y, nr));
    w.end_x = snap(coord_near(sb.org_x, nc));
    w.end_y = snap(coord_near(sb.org_y, nr));
    case ($urandom_range(0, 5))
      0: w.end_x = w.start_x;
      1: w.end_y = w.start_y;
      2: w.end_y = w.start_y + (w.end_x - w.start_x);
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: w.segment_id = NO_SEGMENT;
      1: w.segment_id = next_id;
      default: begin
        next_id = next_id + 16'd1;
        if (next_id == NO_SEGMENT) next_id = 16'd0;
        w.segment_id = next_id;
      end
    endcase
    return w;
  endfunction

  task automatic run_phase(int count, bit pressure);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && sent < count) begin
        if (pressure && sent == 3) hold_off = 1'b1;
        send_segment(rand_segment(), burst > 1 && sent < count - 1);
        burst--; sent++;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
    drain();
  endtask

  initial begin
    in_t w;
    sb = new();
    sb.reset_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // endpoint and corner cases on the reset grid
    w = '{16'sd0, 16'sd0, 16'sd2047, 16'sd2047, 16'd0};        send_segment(w, 1);
    w = '{16'sd2047, 16'sd0, 16'sd0, 16'sd2047, 16'd1};        send_segment(w, 1);
    w = '{16'sd128, 16'sd128, 16'sd1280, 16'sd128, 16'd2};     send_segment(w, 1);
    w = '{16'sd384, 16'sd0, 16'sd384, 16'sd1920, 16'd3};       send_segment(w, 1);
    w = '{16'sd256, 16'sd256, 16'sd256, 16'sd256, 16'd3};      send_segment(w, 1);
    w = '{16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'hFFFF};            send_segment(w, 1);
    w = '{-16'sd1, 16'sd0, 16'sd100, 16'sd100, 16'd4};         send_segment(w, 1);
    w = '{16'sd0, 16'sd0, 16'sd2048, 16'sd10, 16'd5};          send_segment(w, 1);
    w = '{16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767, 16'hFFFE};
    send_segment(w, 1);
    w = '{16'sd0, 16'sd2000, 16'sd2040, 16'sd3, 16'd6};        send_segment(w, 1);
    w = '{16'sd100, 16'sd900, 16'sd1900, 16'sd1000, 16'd7};    send_segment(w, 0);
    drain();
    run_phase(100, 1'b1);
    write_cfg(REG_ORIGIN_X, 16'h8000); write_cfg(REG_ORIGIN_Y, 16'h8000);
    write_cfg(REG_COLUMNS, 16'd0); write_cfg(REG_ROWS, 16'd0);
    run_phase(50, 1'b0);
    write_cfg(REG_ORIGIN_X, 16'h7800); write_cfg(REG_ORIGIN_Y, 16'hFF00);
    write_cfg(REG_COLUMNS, 16'd16); write_cfg(REG_ROWS, 16'd1);
    run_phase(80, 1'b0);
    write_cfg(REG_ORIGIN_X, 16'hFC00); write_cfg(REG_ORIGIN_Y, 16'h7800);
    write_cfg(REG_COLUMNS, 16'hFFFF); write_cfg(REG_ROWS, 16'd7);
    run_phase(120, 1'b0);
    write_cfg(REG_ORIGIN_X, 16'h0123); write_cfg(REG_ORIGIN_Y, 16'hFEDC);
    write_cfg(REG_COLUMNS, 16'd5); write_cfg(REG_ROWS, 16'd16);
    run_phase(150, 1'b0);
    if (sb.errors == 0 && sb.cells_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== segment_grid_cell_binner_top.f =====
design/sgcb_pkg.sv
design/sgcb_div.sv
design/segment_grid_cell_binner_top.sv
dv/segment_grid_cell_binner_top_tb.sv
